### sv/rmh_pkg.sv
// Package: shared constants, types and helpers for the running median block.
package rmh_pkg;
   localparam int HEAP_DEPTH = 512;
   localparam int SAMPLE_WIDTH = 32;
   localparam int ADDR_WIDTH = $clog2(HEAP_DEPTH);
   localparam int COUNT_WIDTH = $clog2(HEAP_DEPTH + 1);
   localparam int TOTAL_WIDTH = $clog2(2 * HEAP_DEPTH + 1);

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // flips a signed sample to offset-binary and back
   localparam sample_type SIGN_BIT = sample_type'(1) << (SAMPLE_WIDTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_CHECK,
      ST_POP_RD,
      ST_POP_LAST,
      ST_DN_LOAD,
      ST_DN_RDL,
      ST_DN_RDR,
      ST_DN_CMP,
      ST_PUSH_MOVED,
      ST_TOPS_RD,
      ST_MEDIAN,
      ST_OUT
   } state_type;

   // Compare unit input and output travel together.
   typedef struct packed {
      sample_type a;
      sample_type b;
      logic       dir_max;
   } cmp_req_type;

   typedef struct packed {
      logic prefer;
      logic gt;
   } cmp_rsp_type;
endpackage

### sv/rmh_if.sv
// Interfaces: valid/ready channels for samples and results.
interface rmh_req_if;
   import rmh_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface rmh_rsp_if;
   import rmh_pkg::*;
   logic                   valid;
   logic                   ready;
   sample_type             median;
   logic                   full_res;
   logic [TOTAL_WIDTH-1:0] stored_count;
   modport source (output valid, output median, output full_res, output stored_count,
                   input ready);
   modport sink (input valid, input median, input full_res, input stored_count,
                 output ready);
endinterface

### sv/rmh_ram.sv
// Generic single-port RAM with registered read.
module rmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/rmh_cmp.sv
// Shared compare unit: offset-binary ordering for both heap directions.
module rmh_cmp (
   input  rmh_pkg::cmp_req_type req,
   output rmh_pkg::cmp_rsp_type rsp
);
   import rmh_pkg::*;
   always_comb begin
      rsp.gt = req.a > req.b;
      rsp.prefer = req.dir_max ? (req.a > req.b) : (req.a < req.b);
   end
endmodule

### sv/running_median_two_heaps.sv
// Top level: running median over signed samples kept in two heaps.
// One item in, one item out. Samples are held offset-binary in two 512-entry
// single-port RAMs (lower max-heap, upper min-heap); a small sequencer walks
// the heaps one level per step, using a single shared compare unit. An item
// without a rebalance is decided, sifts up one level per step, passes the
// balance check, then the tops are read and the median is formed. A rebalance
// pops the top, sifts the last entry down, pushes the popped top into the other
// heap with a second sift-up and runs one more balance check. A dropped sample
// goes straight to the result. The result waits as long as the receiver stalls,
// and the input is not ready until the result has been taken. Steps are set by
// the RAM port: one access per cycle with registered read. No clearing pass:
// only entries below each count are read. A sample aimed at a full heap is
// dropped and flagged with full_res; median and count then report the
// unchanged store.
module running_median_two_heaps (
   input logic clock,
   input logic reset,
   rmh_req_if.sink   req,
   rmh_rsp_if.source rsp
);
   import rmh_pkg::*;

   state_type state_ff, state_in;
   count_type lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   sample_type med_ff, med_in;     // biased median of current store
   sample_type val_ff, val_in;     // value being sifted (the hole's value)
   sample_type hold_ff, hold_in;   // better of value and left child
   sample_type moved_ff, moved_in; // popped top during rebalance
   addr_type idx_ff, idx_in;       // current hole
   logic side_ff, side_in;         // 1: working on upper heap
   logic reb_ff, reb_in;           // rebalance already done for this item
   logic full_ff, full_in;
   logic lsel_ff, lsel_in;         // left child beat the value

   // RAM ports
   logic l_we, u_we;
   addr_type l_addr, u_addr;
   sample_type l_wdata, u_wdata, l_rdata, u_rdata;

   rmh_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) lower_ram (
      .clock(clock), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
   rmh_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HEAP_DEPTH)) upper_ram (
      .clock(clock), .we(u_we), .addr(u_addr), .wdata(u_wdata), .rdata(u_rdata));

   cmp_req_type cq;
   cmp_rsp_type cr;
   rmh_cmp cmp_unit (.req(cq), .rsp(cr));

   sample_type rd;
   count_type cur_n;
   addr_type par;
   logic [ADDR_WIDTH:0] lch, rch;
   logic [SAMPLE_WIDTH:0] msum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lcnt_ff  <= '0;
         ucnt_ff  <= '0;
         med_ff   <= SIGN_BIT;
      end else begin
         state_ff <= state_in;
         lcnt_ff  <= lcnt_in;
         ucnt_ff  <= ucnt_in;
         med_ff   <= med_in;
      end
      val_ff   <= val_in;
      hold_ff  <= hold_in;
      moved_ff <= moved_in;
      idx_ff   <= idx_in;
      side_ff  <= side_in;
      reb_ff   <= reb_in;
      full_ff  <= full_in;
      lsel_ff  <= lsel_in;
   end

   always_comb begin
      state_in = state_ff;
      lcnt_in = lcnt_ff;
      ucnt_in = ucnt_ff;
      med_in = med_ff;
      val_in = val_ff;
      hold_in = hold_ff;
      moved_in = moved_ff;
      idx_in = idx_ff;
      side_in = side_ff;
      reb_in = reb_ff;
      full_in = full_ff;
      lsel_in = lsel_ff;
      l_we = 1'b0;
      u_we = 1'b0;
      l_addr = idx_ff;
      u_addr = idx_ff;
      l_wdata = val_ff;
      u_wdata = val_ff;
      rd = side_ff ? u_rdata : l_rdata;
      cur_n = side_ff ? ucnt_ff : lcnt_ff;
      par = (idx_ff - 1'b1) >> 1;
      lch = {idx_ff, 1'b1};
      rch = lch + 1'b1;
      msum = '0;
      cq.a = val_ff;
      cq.b = med_ff;
      cq.dir_max = ~side_ff;
      req.ready = 1'b0;
      rsp.valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               val_in = req.sample ^ SIGN_BIT;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // compare with the median from before the insert; ties go low
            side_in = cr.gt;
            reb_in = 1'b0;
            full_in = cr.gt ? (ucnt_ff == count_type'(HEAP_DEPTH))
                            : (lcnt_ff == count_type'(HEAP_DEPTH));
            if (full_in) begin
               state_in = ST_OUT;
            end else begin
               idx_in = addr_type'(cr.gt ? ucnt_ff : lcnt_ff);
               state_in = ST_UP_RD;
            end
         end
         ST_UP_RD: begin
            // at the root: settle the value; else fetch the parent
            if (idx_ff == '0) begin
               if (side_ff) begin
                  u_we = 1'b1;
                  ucnt_in = ucnt_ff + 1'b1;
               end else begin
                  l_we = 1'b1;
                  lcnt_in = lcnt_ff + 1'b1;
               end
               state_in = ST_CHECK;
            end else begin
               l_addr = par;
               u_addr = par;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            // parent moves down into the hole when the value wins
            cq.b = rd;
            if (side_ff) begin
               u_we = 1'b1;
            end else begin
               l_we = 1'b1;
            end
            if (cr.prefer) begin
               l_wdata = rd;
               u_wdata = rd;
               idx_in = par;
               state_in = ST_UP_RD;
            end else begin
               if (side_ff) begin
                  ucnt_in = ucnt_ff + 1'b1;
               end else begin
                  lcnt_in = lcnt_ff + 1'b1;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // sizes two apart: move the larger heap's top across
            if (!reb_ff && lcnt_ff == ucnt_ff + 2'd2) begin
               side_in = 1'b0;
               reb_in = 1'b1;
               state_in = ST_POP_RD;
            end else if (!reb_ff && ucnt_ff == lcnt_ff + 2'd2) begin
               side_in = 1'b1;
               reb_in = 1'b1;
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_TOPS_RD;
            end
         end
         ST_POP_RD: begin
            l_addr = '0;
            u_addr = '0;
            state_in = ST_POP_LAST;
         end
         ST_POP_LAST: begin
            // capture the top, fetch the last entry, shrink the heap
            moved_in = rd;
            l_addr = addr_type'(cur_n - 1'b1);
            u_addr = addr_type'(cur_n - 1'b1);
            if (side_ff) begin
               ucnt_in = ucnt_ff - 1'b1;
            end else begin
               lcnt_in = lcnt_ff - 1'b1;
            end
            state_in = ST_DN_LOAD;
         end
         ST_DN_LOAD: begin
            // last entry sifts down from the root
            val_in = rd;
            idx_in = '0;
            state_in = ST_DN_RDL;
         end
         ST_DN_RDL: begin
            if (lch < (ADDR_WIDTH + 1)'(cur_n)) begin
               l_addr = lch[ADDR_WIDTH-1:0];
               u_addr = lch[ADDR_WIDTH-1:0];
               state_in = ST_DN_RDR;
            end else begin
               // leaf: value settles here
               if (side_ff) begin
                  u_we = 1'b1;
               end else begin
                  l_we = 1'b1;
               end
               state_in = ST_PUSH_MOVED;
            end
         end
         ST_DN_RDR: begin
            // left child vs value
            cq.a = rd;
            cq.b = val_ff;
            lsel_in = cr.prefer;
            hold_in = cr.prefer ? rd : val_ff;
            if (rch < (ADDR_WIDTH + 1)'(cur_n)) begin
               l_addr = rch[ADDR_WIDTH-1:0];
               u_addr = rch[ADDR_WIDTH-1:0];
               state_in = ST_DN_CMP;
            end else begin
               if (side_ff) begin
                  u_we = 1'b1;
               end else begin
                  l_we = 1'b1;
               end
               if (cr.prefer) begin
                  l_wdata = rd;
                  u_wdata = rd;
                  idx_in = lch[ADDR_WIDTH-1:0];
                  state_in = ST_DN_RDL;
               end else begin
                  state_in = ST_PUSH_MOVED;
               end
            end
         end
         ST_DN_CMP: begin
            // right child vs the better of value and left child
            cq.a = rd;
            cq.b = hold_ff;
            if (side_ff) begin
               u_we = 1'b1;
            end else begin
               l_we = 1'b1;
            end
            if (cr.prefer) begin
               l_wdata = rd;
               u_wdata = rd;
               idx_in = rch[ADDR_WIDTH-1:0];
               state_in = ST_DN_RDL;
            end else if (lsel_ff) begin
               l_wdata = hold_ff;
               u_wdata = hold_ff;
               idx_in = lch[ADDR_WIDTH-1:0];
               state_in = ST_DN_RDL;
            end else begin
               state_in = ST_PUSH_MOVED;
            end
         end
         ST_PUSH_MOVED: begin
            // sift-down done: push the moved top into the other heap
            side_in = ~side_ff;
            val_in = moved_ff;
            idx_in = addr_type'(side_ff ? lcnt_ff : ucnt_ff);
            state_in = ST_UP_RD;
         end
         ST_TOPS_RD: begin
            l_addr = '0;
            u_addr = '0;
            state_in = ST_MEDIAN;
         end
         ST_MEDIAN: begin
            // odd sum below the bias point is negative: round up toward zero
            if (lcnt_ff == '0 && ucnt_ff == '0) begin
               med_in = SIGN_BIT;
            end else if (lcnt_ff == ucnt_ff) begin
               msum = {1'b0, l_rdata} + {1'b0, u_rdata};
               med_in = msum[SAMPLE_WIDTH:1];
               if (msum[0] && !msum[SAMPLE_WIDTH]) begin
                  med_in = msum[SAMPLE_WIDTH:1] + 1'b1;
               end
            end else begin
               med_in = (lcnt_ff > ucnt_ff) ? l_rdata : u_rdata;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.median = med_ff ^ SIGN_BIT;
   assign rsp.full_res = full_ff;
   assign rsp.stored_count = TOTAL_WIDTH'(lcnt_ff) + TOTAL_WIDTH'(ucnt_ff);

   // heaps never exceed their depth
   assert property (@(posedge clock) disable iff (reset)
      lcnt_ff <= count_type'(HEAP_DEPTH) && ucnt_ff <= count_type'(HEAP_DEPTH))
      else $error("heap count overflow");
   // heaps stay balanced within one when idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (lcnt_ff <= ucnt_ff + 1'b1 && ucnt_ff <= lcnt_ff + 1'b1))
      else $error("heaps out of balance");
   // a dropped sample leaves the counts alone
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.full_res) |=> $stable(lcnt_ff) && $stable(ucnt_ff))
      else $error("counts changed on drop");
endmodule
